### hw/rtl/online_two_means_clustering_core_defines.svh
// Assertion macros for the two-means clustering core
`ifndef ONLINE_TWO_MEANS_CLUSTERING_CORE_DEFINES_SVH
`define ONLINE_TWO_MEANS_CLUSTERING_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define OTMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otmc: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define OTMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otmc: next-cycle check failed");
`else
`define OTMC_ASSERT_IMP(lbl, ante, cons)
`define OTMC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/otmc_pkg.sv
// Shared types and constants of the two-means clustering core
`default_nettype none

package otmc_pkg;

  // width of the member count field on the result channel
  localparam int MC_W = 8;

  // configuration register index width and indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED0_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED0_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED1_X = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED1_Y = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_UPD,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start_set;
    logic classify;
    logic update;
    logic div_start;
    logic div_commit;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic drop;
    logic div_done;
    logic div_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/otmc_if.sv
// Request and result channel interfaces of the two-means clustering core
`default_nettype none

interface otmc_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last;

  modport source (output valid, point_x, point_y, last, input ready);
  modport sink   (input valid, point_x, point_y, last, output ready);
endinterface

interface otmc_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         cluster;
  logic signed [COORD_BITS-1:0] centroid_x;
  logic signed [COORD_BITS-1:0] centroid_y;
  logic [7:0]                   member_count;
  logic                         dropped;

  modport source (output valid, cluster, centroid_x, centroid_y, member_count, dropped,
                  input ready);
  modport sink   (input valid, cluster, centroid_x, centroid_y, member_count, dropped,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/otmc_div.sv
// Radix-2 restoring divider, signed dividend by unsigned divisor, truncating
`default_nettype none

module otmc_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [DVD_W-1:0] dividend,
  input  wire logic        [DVS_W-1:0] divisor,
  output      logic                    busy,
  output      logic                    done,
  output      logic signed [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, done_r, neg_r;
  logic [DVD_W-1:0]  mag_r;
  logic [DVS_W-1:0]  rem_r, dvs_r;
  logic [STEP_W-1:0] step_r;
  logic [DVS_W:0]    trial, diff;
  logic              fit;
  logic [DVD_W-1:0]  neg_dvd;

  // one quotient bit per cycle
  assign trial   = {rem_r, mag_r[DVD_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign fit     = trial >= {1'b0, dvs_r};
  assign neg_dvd = -dividend;

  // control: busy while the DVD_W quotient bits are formed, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitude shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DVD_W-1];
      mag_r <= dividend[DVD_W-1] ? neg_dvd : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      mag_r <= {mag_r[DVD_W-2:0], fit};
      rem_r <= fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? -mag_r : mag_r;

endmodule

`default_nettype wire

### hw/rtl/otmc_ctrl.sv
// Sequencing controller of the two-means clustering core
`default_nettype none

module otmc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic                 out_ready,
  output      logic                 out_valid,
  input  wire otmc_pkg::dp_sts_t    sts,
  output      otmc_pkg::ctrl_cmd_t  cmd
);

  import otmc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        set_begins_r, set_begins_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIST;
      ST_DIST:   state_nxt = ST_UPD;
      ST_UPD:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = sts.drop ? ST_EMIT : ST_DIV;
      ST_DIV:    if (sts.div_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and flag updates
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    set_begins_nxt = set_begins_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept     = 1'b1;
          cmd.start_set  = set_begins_r;
          set_begins_nxt = 1'b0;
        end
      end
      ST_DIST:   cmd.classify  = 1'b1;
      ST_UPD:    cmd.update    = 1'b1;
      ST_DSTART: cmd.div_start = !sts.drop;
      ST_DIV:    cmd.div_commit = sts.div_done;
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit       = 1'b1;
          out_valid_nxt  = 1'b1;
          set_begins_nxt = sts.last;
        end
      end
      default: ;
    endcase
  end

  // hold state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      set_begins_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      set_begins_r <= set_begins_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/otmc_datapath.sv
// Datapath of the two-means clustering core: seeds, cluster state, distance, dividers
`default_nettype none

module otmc_datapath #(
  parameter int MAX_MEMBERS = 128,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [otmc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [COORD_BITS-1:0]                 cfg_wdata,
  input  wire logic signed [COORD_BITS-1:0]          point_x,
  input  wire logic signed [COORD_BITS-1:0]          point_y,
  input  wire logic                                  last,
  input  wire otmc_pkg::ctrl_cmd_t                   cmd,
  output      otmc_pkg::dp_sts_t                     sts,
  output      logic                                  out_cluster,
  output      logic signed [COORD_BITS-1:0]          out_centroid_x,
  output      logic signed [COORD_BITS-1:0]          out_centroid_y,
  output      logic [otmc_pkg::MC_W-1:0]             out_member_count,
  output      logic                                  out_dropped
);

  import otmc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int DIST_W = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] seed_r [4];
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic                         last_r;
  logic signed [COORD_BITS-1:0] cx_r [2];
  logic signed [COORD_BITS-1:0] cy_r [2];
  logic signed [SUM_W-1:0]      sx_r [2];
  logic signed [SUM_W-1:0]      sy_r [2];
  logic [CNT_W-1:0]             cnt_r [2];
  logic                         c_r, drop_r, full;
  logic [DIST_W-1:0]            d0, d1;
  logic                         busy_x, busy_y, done_x, done_y;
  logic signed [SUM_W-1:0]      qx, qy;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] nd;
    d  = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    nd = -d;
    return d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  // seed registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) seed_r[i] <= '0;
    end else if (cfg_we) begin
      seed_r[cfg_addr] <= cfg_wdata;
    end
  end

  // Manhattan distance to both centroids
  assign d0 = {1'b0, abs_diff(px_r, cx_r[0])} + {1'b0, abs_diff(py_r, cy_r[0])};
  assign d1 = {1'b0, abs_diff(px_r, cx_r[1])} + {1'b0, abs_diff(py_r, cy_r[1])};

  assign full = cnt_r[c_r] >= CNT_W'(MAX_MEMBERS);

  // request capture, cluster choice and drop flag
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r   <= point_x;
      py_r   <= point_y;
      last_r <= last;
    end
    if (cmd.classify) c_r <= (d0 < d1) ? 1'b0 : 1'b1;
    if (cmd.update) drop_r <= full;
  end

  // cluster state: reload at set start, accumulate, commit means
  always_ff @(posedge clk) begin
    if (cmd.start_set) begin
      cx_r[0] <= seed_r[REG_SEED0_X];
      cy_r[0] <= seed_r[REG_SEED0_Y];
      cx_r[1] <= seed_r[REG_SEED1_X];
      cy_r[1] <= seed_r[REG_SEED1_Y];
      for (int k = 0; k < 2; k++) begin
        sx_r[k]  <= '0;
        sy_r[k]  <= '0;
        cnt_r[k] <= '0;
      end
    end else if (cmd.update && !full) begin
      sx_r[c_r]  <= sx_r[c_r] + {{CNT_W{px_r[COORD_BITS-1]}}, px_r};
      sy_r[c_r]  <= sy_r[c_r] + {{CNT_W{py_r[COORD_BITS-1]}}, py_r};
      cnt_r[c_r] <= cnt_r[c_r] + 1'b1;
    end else if (cmd.div_commit) begin
      cx_r[c_r] <= qx[COORD_BITS-1:0];
      cy_r[c_r] <= qy[COORD_BITS-1:0];
    end
  end

  // mean of x and y, one divider per coordinate
  otmc_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sx_r[c_r]),
    .divisor  (cnt_r[c_r]),
    .busy     (busy_x),
    .done     (done_x),
    .quotient (qx)
  );

  otmc_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sy_r[c_r]),
    .divisor  (cnt_r[c_r]),
    .busy     (busy_y),
    .done     (done_y),
    .quotient (qy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cluster      <= c_r;
      out_centroid_x   <= cx_r[c_r];
      out_centroid_y   <= cy_r[c_r];
      out_member_count <= MC_W'(cnt_r[c_r]);
      out_dropped      <= drop_r;
    end
  end

  assign sts.last     = last_r;
  assign sts.drop     = drop_r;
  assign sts.div_done = done_x & done_y;
  assign sts.div_busy = busy_x | busy_y;

endmodule

`default_nettype wire

### hw/rtl/online_two_means_clustering_core.sv
// Top level of the online two-means clustering core
//
// Requests arrive on in_if (point_x, point_y, last) with valid/ready; each
// request yields exactly one result on out_if (cluster, centroid_x,
// centroid_y, member_count, dropped). Seeds are written through cfg_we,
// cfg_addr and cfg_wdata; the user must do so only while the core is idle,
// as the core does not enforce it. They take effect at the next set start.
// One request is worked at a time. The radix-2 dividers form one quotient
// bit per cycle over the accumulator width, with the x and y means computed
// side by side; a dropped point skips the division. The result appears in
// the same cycle that in_if.ready returns.
// Results sit in an output register; a new request is accepted while it
// waits, and that request then holds in its last step until the receiver
// takes the old result. Reset clears the seeds to zero and marks the next
// request as the start of a set.
`default_nettype none
`include "online_two_means_clustering_core_defines.svh"

module online_two_means_clustering_core #(
  parameter int MAX_MEMBERS = 128,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  otmc_in_if.sink                              in_if,
  otmc_out_if.source                           out_if,
  input  wire logic                            cfg_we,
  input  wire logic [otmc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [COORD_BITS-1:0]           cfg_wdata
);

  import otmc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;
  logic      out_valid;

  // sequencing
  otmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  otmc_datapath #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .point_x          (in_if.point_x),
    .point_y          (in_if.point_y),
    .last             (in_if.last),
    .cmd              (cmd),
    .sts              (sts),
    .out_cluster      (out_if.cluster),
    .out_centroid_x   (out_if.centroid_x),
    .out_centroid_y   (out_if.centroid_y),
    .out_member_count (out_if.member_count),
    .out_dropped      (out_if.dropped)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  // no new request while a division is running
  `OTMC_ASSERT_IMP(a_ready_not_dividing, in_ready, !sts.div_busy)
  // a result is loaded only into a free output register
  `OTMC_ASSERT_IMP(a_emit_into_free, cmd.emit, !out_valid || out_if.ready)
  // one request in work at a time
  `OTMC_ASSERT_NXT(a_single_request, cmd.accept, !in_ready)

endmodule

`default_nettype wire

### sim/tb_online_two_means_clustering_core.sv
// Self-checking testbench of the online two-means clustering core
module tb_online_two_means_clustering_core;
  timeunit 1ns;
  timeprecision 1ps;

  import otmc_pkg::*;

  localparam int MAX_MEMBERS  = 128;
  localparam int COORD_W      = 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int SETTLE_CYCLES = 60;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } point_req_t;

  typedef struct packed {
    logic                      cluster;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic [MC_W-1:0]           member_count;
    logic                      dropped;
  } cluster_update_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [COORD_W-1:0] cfg_wdata;

  otmc_in_if  #(.COORD_BITS(COORD_W)) in_ch ();
  otmc_out_if #(.COORD_BITS(COORD_W)) out_ch ();

  online_two_means_clustering_core #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .COORD_BITS (COORD_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // clustering state mirrored from the core
  logic signed [COORD_W-1:0] seed_reg [4];
  int cen_x [2];
  int cen_y [2];
  int acc_x [2];
  int acc_y [2];
  int members [2];
  bit restart_set = 1'b1;

  point_req_t      point_fifo [$];
  cluster_update_t predicted_updates [$];
  int n_pushed = 0;
  int n_checked = 0;
  int fail_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int idle_cycles = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  function automatic int manhattan(int ax, int ay, int bx, int by);
    int dx;
    int dy;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx + dy;
  endfunction

  // classify one point and fold it into its cluster
  function automatic cluster_update_t assign_point(logic signed [COORD_W-1:0] px,
                                                   logic signed [COORD_W-1:0] py,
                                                   logic last_flag);
    cluster_update_t r;
    int d0;
    int d1;
    int k;
    if (restart_set) begin
      cen_x[0] = seed_reg[REG_SEED0_X];
      cen_y[0] = seed_reg[REG_SEED0_Y];
      cen_x[1] = seed_reg[REG_SEED1_X];
      cen_y[1] = seed_reg[REG_SEED1_Y];
      for (int i = 0; i < 2; i++) begin
        acc_x[i] = 0;
        acc_y[i] = 0;
        members[i] = 0;
      end
      restart_set = 1'b0;
    end
    d0 = manhattan(px, py, cen_x[0], cen_y[0]);
    d1 = manhattan(px, py, cen_x[1], cen_y[1]);
    // a tie goes to cluster 1
    k = (d0 < d1) ? 0 : 1;
    r.dropped = (members[k] >= MAX_MEMBERS);
    if (!r.dropped) begin
      acc_x[k] += px;
      acc_y[k] += py;
      members[k] += 1;
      cen_x[k] = acc_x[k] / members[k];
      cen_y[k] = acc_y[k] / members[k];
    end
    r.cluster      = k[0];
    r.centroid_x   = 16'(cen_x[k]);
    r.centroid_y   = 16'(cen_y[k]);
    r.member_count = 8'(members[k]);
    if (last_flag) restart_set = 1'b1;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_idle(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // near a center, anywhere, or on an extreme value
  function automatic logic signed [COORD_W-1:0] pick_coord(int center, int spread, bit focused);
    int v;
    int r;
    r = $urandom_range(0, 9);
    if (focused || r < 5) begin
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
    end else if (r < 8) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      case ($urandom_range(0, 4))
        0: v = -32768;
        1: v = -1;
        2: v = 0;
        3: v = 1;
        default: v = 32767;
      endcase
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic void push_point(logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y, logic last_flag);
    point_req_t req;
    req.x = x;
    req.y = y;
    req.last = last_flag;
    point_fifo.push_back(req);
    n_pushed++;
  endfunction

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic signed [COORD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    seed_reg[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_seeds(logic signed [COORD_W-1:0] s0x, logic signed [COORD_W-1:0] s0y,
                            logic signed [COORD_W-1:0] s1x, logic signed [COORD_W-1:0] s1y);
    write_reg(REG_SEED0_X, s0x);
    write_reg(REG_SEED0_Y, s0y);
    write_reg(REG_SEED1_X, s1x);
    write_reg(REG_SEED1_Y, s1y);
    cfg_we <= 1'b0;
  endtask

  // wait for every result, then let the core go idle
  task automatic drain_and_settle();
    while (n_checked != n_pushed) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver: predict each accepted request, then load the next
  always @(posedge clk) begin : request_driver
    point_req_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predicted_updates.push_back(assign_point(in_ch.point_x, in_ch.point_y, in_ch.last));
      end
      if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (point_fifo.size() != 0) begin
        req = point_fifo.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.point_x <= req.x;
        in_ch.point_y <= req.y;
        in_ch.last <= req.last;
        send_gap <= pick_idle(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor: compare against the oldest prediction, stall at random
  always @(posedge clk) begin : result_monitor
    cluster_update_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_updates.size() == 0) begin
          $error("result with no request pending: cluster %0d", out_ch.cluster);
          fail_count++;
        end else begin
          want = predicted_updates.pop_front();
          n_checked++;
          if (out_ch.cluster !== want.cluster) begin
            $error("cluster: expected %0d, got %0d", want.cluster, out_ch.cluster);
            fail_count++;
          end
          if (out_ch.centroid_x !== want.centroid_x) begin
            $error("centroid_x: expected %0d, got %0d", want.centroid_x, out_ch.centroid_x);
            fail_count++;
          end
          if (out_ch.centroid_y !== want.centroid_y) begin
            $error("centroid_y: expected %0d, got %0d", want.centroid_y, out_ch.centroid_y);
            fail_count++;
          end
          if (out_ch.member_count !== want.member_count) begin
            $error("member_count: expected %0d, got %0d", want.member_count,
                   out_ch.member_count);
            fail_count++;
          end
          if (out_ch.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, out_ch.dropped);
            fail_count++;
          end
        end
      end
      if (recv_stall != 0) begin
        out_ch.ready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_stall <= pick_idle(out_calm);
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : stall_watch
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic signed [COORD_W-1:0] s0x, s0y, s1x, s1y;
    int base;
    int c;
    int target;
    int nsets;
    int len;
    int spread;
    bit near1;
    bit tail_open;
    bit open_set;

    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    for (int i = 0; i < 4; i++) seed_reg[i] = '0;
    open_set = 1'b0;

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    drain_and_settle();

    // all seeds zero: the first point is a tie, then the corners
    load_seeds('0, '0, '0, '0);
    push_point('0, '0, 1'b0);
    push_point(16'sh8000, 16'sh8000, 1'b0);
    push_point(16'sh7fff, 16'sh7fff, 1'b0);
    push_point(16'sh7fff, 16'sh8000, 1'b0);
    push_point(16'sh8000, 16'sh7fff, 1'b1);
    drain_and_settle();

    // seeds on opposite corners; first point lies exactly between them
    load_seeds(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    push_point(-16'sd1, '0, 1'b0);
    push_point(-16'sd1, -16'sd1, 1'b0);
    push_point('0, '0, 1'b0);
    push_point(16'sh8000, 16'sh8000, 1'b0);
    push_point(16'sh7fff, 16'sh7fff, 1'b0);
    push_point(16'sd100, -16'sd100, 1'b0);
    drain_and_settle();

    // new seeds in the middle of a set apply only after the set ends
    load_seeds(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    push_point(16'sd5, 16'sd5, 1'b1);
    push_point(16'sh7fff, 16'sh8000, 1'b0);
    push_point(16'sh8000, 16'sh7fff, 1'b0);
    push_point('0, '0, 1'b1);
    drain_and_settle();

    base = n_pushed;
    while (n_pushed - base < RANDOM_ITEMS) begin
      in_calm = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        // overfill one cluster so it drops points; end the set on a dropped one
        target = $urandom_range(0, 1);
        c = $urandom_range(12000, 24000);
        if (target == 1) load_seeds(16'(-c), 16'(-c), 16'(c), 16'(c));
        else load_seeds(16'(c), 16'(c), 16'(-c), 16'(-c));
        if (open_set) push_point(pick_coord(0, 0, 1'b0), pick_coord(0, 0, 1'b0), 1'b1);
        len = $urandom_range(MAX_MEMBERS + 5, MAX_MEMBERS + 40);
        for (int i = 0; i < len; i++) begin
          push_point(pick_coord(c, 1500, 1'b1), pick_coord(c, 1500, 1'b1), i == len - 1);
        end
        open_set = 1'b0;
      end else begin
        s0x = pick_seed();
        s0y = pick_seed();
        s1x = pick_seed();
        s1y = pick_seed();
        load_seeds(s0x, s0y, s1x, s1y);
        nsets = $urandom_range(1, 3);
        for (int s = 0; s < nsets; s++) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 30);
          // sometimes leave the set open across the next seed change
          tail_open = (s == nsets - 1) && ($urandom_range(0, 3) == 0);
          for (int i = 0; i < len; i++) begin
            near1 = 1'($urandom_range(0, 1));
            spread = ($urandom_range(0, 3) != 0) ? 600 : 6000;
            push_point(pick_coord(near1 ? s1x : s0x, spread, 1'b0),
                       pick_coord(near1 ? s1y : s0y, spread, 1'b0),
                       (i == len - 1) && !tail_open);
          end
          open_set = tail_open;
        end
      end
      drain_and_settle();
    end

    if (fail_count == 0 && predicted_updates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/otmc_pkg.sv
hw/rtl/otmc_if.sv
hw/rtl/otmc_div.sv
hw/rtl/otmc_ctrl.sv
hw/rtl/otmc_datapath.sv
hw/rtl/online_two_means_clustering_core.sv
sim/tb_online_two_means_clustering_core.sv
